>>> src/rational_arithmetic_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
// Depends on nothing; included by the top level.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau assertion failed");
// next-cycle implication checked outside reset
`define RAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau assertion failed");
`endif

>>> src/rau_pkg.sv
// Types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int FW = 64;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_MUL = 2'd1,
    REQ_SIMP = 2'd2,
    REQ_TRUNC = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [FW-1:0] a_num;
    logic signed [FW-1:0] a_den;
    logic signed [FW-1:0] b_num;
    logic signed [FW-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FW-1:0] res_num;
    logic signed [FW-1:0] res_den;
    logic signed [FW-1:0] int_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1, ST_M1W,
    ST_M2, ST_M2W,
    ST_M3, ST_M3W,
    ST_GCD, ST_GCDW,
    ST_DIVN, ST_DIVNW,
    ST_DIVD, ST_DIVDW,
    ST_FIX,
    ST_DONE
  } state_t;
endpackage

>>> src/rau_mul.sv
// Shift-add multiplier, one bit a cycle, low word kept (wraps).
// No dependencies; rau_pkg is not used.
module rau_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic         done,
  output logic [W-1:0] prod
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  // add shifted multiplicand when the current multiplier bit is set
  always_comb begin
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (go) begin
      acc_nxt = '0; a_nxt = op_a; b_nxt = op_b;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

>>> src/rau_div.sv
// Restoring unsigned divider, one quotient bit a cycle.
// Shared by the GCD steps, the reduction divides and truncation.
module rau_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt, d_r, d_nxt;
  logic [W:0]    r_r, r_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  // shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[W-1:0], q_r[W-1]};
    if (go) begin
      q_nxt = dividend; d_nxt = divisor; r_nxt = '0;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[W-1:0];
endmodule

>>> src/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, multiply, reduce and truncate of rationals.
// Products, Euclid steps and divides each run on the shared bit-serial
// multiplier and divider. One item at a time:
// busy stays high from acceptance to the out_valid strobe. No overlap.
// Reset (rst_n low, synchronous) returns the sequencer to idle.
// The receiver cannot stall; each result shows for one cycle.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  `include "rational_arithmetic_unit_macros.svh"

  localparam int W = WORD_BITS;

  state_t state_r, state_nxt;
  logic [1:0] req_r, req_nxt;
  logic [W-1:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [W-1:0] x_r, x_nxt, y_r, y_nxt, p_r, p_nxt;
  logic [W-1:0] num_r, num_nxt, den_r, den_nxt, iv_r, iv_nxt;
  logic         vld_r, vld_nxt;

  logic         mgo, mdone, dgo, ddone;
  logic [W-1:0] ma, mb, mp, dn, dd, dq, drm;

  rau_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mgo), .op_a(ma), .op_b(mb),
    .done(mdone), .prod(mp)
  );
  rau_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(dn), .divisor(dd),
    .done(ddone), .quo(dq), .rem(drm)
  );

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // sequence the shared units
  always_comb begin
    state_nxt = state_r; req_nxt = req_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    x_nxt = x_r; y_nxt = y_r; p_nxt = p_r;
    num_nxt = num_r; den_nxt = den_r; iv_nxt = iv_r;
    vld_nxt = 1'b0;
    mgo = 1'b0; ma = '0; mb = '0;
    dgo = 1'b0; dn = '0; dd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_item.req_type;
          an_nxt = in_item.a_num[W-1:0]; ad_nxt = in_item.a_den[W-1:0];
          bn_nxt = in_item.b_num[W-1:0]; bd_nxt = in_item.b_den[W-1:0];
          num_nxt = '0; den_nxt = '0; iv_nxt = '0;
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        case (req_r)
          REQ_ADD, REQ_MUL: begin
            mgo = 1'b1; ma = ad_r; mb = bd_r; state_nxt = ST_M1W;
          end
          REQ_SIMP: begin
            num_nxt = an_r; den_nxt = ad_r; state_nxt = ST_GCD;
            x_nxt = mag(an_r); y_nxt = mag(ad_r);
          end
          default: begin
            if (ad_r == '0) state_nxt = ST_DONE;
            else begin
              dgo = 1'b1; dn = mag(an_r); dd = mag(ad_r);
              state_nxt = ST_DIVNW;
            end
          end
        endcase
      end
      ST_M1W: if (mdone) begin
        den_nxt = mp; state_nxt = ST_M2;
      end
      ST_M2: begin
        mgo = 1'b1; ma = an_r; mb = (req_r == REQ_ADD) ? bd_r : bn_r;
        state_nxt = ST_M2W;
      end
      ST_M2W: if (mdone) begin
        p_nxt = mp;
        if (req_r == REQ_ADD) state_nxt = ST_M3;
        else begin
          num_nxt = mp; x_nxt = mag(mp); y_nxt = mag(den_r);
          state_nxt = ST_GCD;
        end
      end
      ST_M3: begin
        mgo = 1'b1; ma = bn_r; mb = ad_r; state_nxt = ST_M3W;
      end
      ST_M3W: if (mdone) begin
        num_nxt = p_r + mp; x_nxt = mag(p_r + mp); y_nxt = mag(den_r);
        state_nxt = ST_GCD;
      end
      // one Euclid step per divide
      ST_GCD: begin
        if (y_r == '0) begin
          if (x_r > W'(1)) begin
            dgo = 1'b1; dn = mag(num_r); dd = x_r; state_nxt = ST_DIVNW;
          end else state_nxt = ST_FIX;
        end else begin
          dgo = 1'b1; dn = x_r; dd = y_r; state_nxt = ST_GCDW;
        end
      end
      ST_GCDW: if (ddone) begin
        x_nxt = y_r; y_nxt = drm; state_nxt = ST_GCD;
      end
      ST_DIVNW: if (ddone) begin
        if (req_r == REQ_TRUNC) begin
          iv_nxt = (an_r[W-1] != ad_r[W-1]) ? (~dq + 1'b1) : dq;
          state_nxt = ST_DONE;
        end else begin
          num_nxt = num_r[W-1] ? (~dq + 1'b1) : dq;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        dgo = 1'b1; dn = mag(den_r); dd = x_r; state_nxt = ST_DIVDW;
      end
      ST_DIVDW: if (ddone) begin
        den_nxt = den_r[W-1] ? (~dq + 1'b1) : dq; state_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (den_r[W-1]) begin
          num_nxt = ~num_r + 1'b1; den_nxt = ~den_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        vld_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; vld_r <= vld_nxt;
    end
    req_r <= req_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt;
    bd_r <= bd_nxt; x_r <= x_nxt; y_r <= y_nxt; p_r <= p_nxt;
    num_r <= num_nxt; den_r <= den_nxt; iv_r <= iv_nxt;
  end

  // sign-extend results to the field width
  assign busy = (state_r != ST_IDLE);
  assign out_valid = vld_r;
  assign out_item.res_num = FW'($signed(num_r));
  assign out_item.res_den = FW'($signed(den_r));
  assign out_item.int_value = FW'($signed(iv_r));

  `RAU_ASSERT_IMP(a_busy_no_valid, out_valid, !busy)
  `RAU_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `RAU_ASSERT_IMP(a_units_idle, mdone, !ddone)
endmodule
